@@ rtl/core/i2cseq_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Types and codes shared by the I2C master transaction sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cseq_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_LOAD  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_ACK_ON  = 3'd1,
    CMD_START   = 3'd2,
    CMD_ADDR_WR = 3'd3,
    CMD_ADDR_RD = 3'd4,
    CMD_SEND    = 3'd5,
    CMD_READ    = 3'd6,
    CMD_STOP    = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE            = 4'd0,
    ST_TX_START        = 4'd1,
    ST_TX_ADDRESS      = 4'd2,
    ST_TX_DATA         = 4'd3,
    ST_RX_START        = 4'd4,
    ST_RX_ADDRESS      = 4'd5,
    ST_RX_DATA         = 4'd6,
    ST_STOP            = 4'd7,
    ST_WAIT_BUSY       = 4'd8,
    ST_WAIT_START      = 4'd9,
    ST_WAIT_TX_ADDRESS = 4'd10,
    ST_WAIT_TX_DATA    = 4'd11,
    ST_WAIT_RX_ADDRESS = 4'd12,
    ST_WAIT_RX_DATA    = 4'd13
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [6:0]  device_address;
    logic [4:0]  byte_count;
    logic        notify;
    logic [3:0]  byte_index;
    logic [7:0]  data_byte;
    logic        bus_busy;
    logic        start_done;
    logic        tx_addr_acked;
    logic        rx_addr_acked;
    logic        byte_sent;
    logic        byte_received;
  } in_item_t;

  typedef struct packed {
    cmd_t        command;
    logic        ack_off;
    logic [6:0]  bus_address;
    logic [7:0]  out_byte;
    logic [3:0]  out_index;
    logic        done_res;
    logic [3:0]  fsm_state;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/i2c_master_transaction_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_core
// Polled I2C master write/read sequencer: one command word per input word.
//
//   channel | dir | tdata                         | tuser
//   s       | in  | request, load or poll tick    | action
//   m       | out | command fields and state      | command
//
// Each word passes an input register, then one step of the sequencer into
// the output register, one word per cycle while the output is not stalled.
// The transmit store has a registered read port addressed by the next
// write position, so a send finds its byte already read out.
// Reset (rst, synchronous) returns the sequencer to idle; the store keeps
// its contents. A stalled output holds both registers; input then waits.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transaction_sequencer_core #(
  parameter int BUF_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // device_address[6:0], byte_count[11:7], notify[12], byte_index[16:13],
  // data_byte[24:17], bus_busy[25], start_done[26], tx_addr_acked[27],
  // rx_addr_acked[28], byte_sent[29], byte_received[30], zero[31]
  input  wire logic [31:0] s_tdata,
  // action[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // ack_off[0], bus_address[7:1], out_byte[15:8], out_index[19:16],
  // done_res[20], fsm_state[24:21], zero[31:25]
  output logic      [31:0] m_tdata,
  // command[2:0]
  output logic      [2:0]  m_tuser
);

  import i2cseq_pkg::*;

  logic      in_valid;
  in_item_t  in_item;
  logic      advance;
  out_item_t step_result;
  out_item_t out_item;
  logic [7:0] tx_byte;
  logic [3:0] write_pos_next;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.action         <= action_t'(s_tuser);
      in_item.device_address <= s_tdata[6:0];
      in_item.byte_count     <= s_tdata[11:7];
      in_item.notify         <= s_tdata[12];
      in_item.byte_index     <= s_tdata[16:13];
      in_item.data_byte      <= s_tdata[24:17];
      in_item.bus_busy       <= s_tdata[25];
      in_item.start_done     <= s_tdata[26];
      in_item.tx_addr_acked  <= s_tdata[27];
      in_item.rx_addr_acked  <= s_tdata[28];
      in_item.byte_sent      <= s_tdata[29];
      in_item.byte_received  <= s_tdata[30];
    end
  end

  i2cseq_step #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_step (
    .clk            (clk),
    .rst            (rst),
    .fire           (advance),
    .item           (in_item),
    .tx_byte        (tx_byte),
    .result         (step_result),
    .write_pos_next (write_pos_next)
  );

  i2cseq_store #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (advance && (in_item.action == ACT_LOAD)),
    .wr_pos  (in_item.byte_index),
    .wr_data (in_item.data_byte),
    .rd_pos  (write_pos_next),
    .rd_data (tx_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_result;
    end
  end

  assign m_tuser = out_item.command;
  assign m_tdata = {7'd0, out_item.fsm_state, out_item.done_res, out_item.out_index,
                    out_item.out_byte, out_item.bus_address, out_item.ack_off};

endmodule

`default_nettype wire

@@ rtl/core/i2cseq_store.sv @@
// ----------------------------------------------------------------------------
// i2cseq_store
// Transmit byte store: one write port and one registered read port with
// write-to-read forwarding. Positions are taken modulo the store depth.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cseq_store #(
  parameter int BUF_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       wr_en,
  input  wire logic [3:0] wr_pos,
  input  wire logic [7:0] wr_data,
  input  wire logic [3:0] rd_pos,
  output logic      [7:0] rd_data
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic [7:0]    mem [BUF_DEPTH];
  logic [AW-1:0] pos_mod [16];
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // Position modulo depth, worked out at elaboration for all 16 positions.
  for (genvar i = 0; i < 16; i++) begin : g_mod
    assign pos_mod[i] = AW'(i % BUF_DEPTH);
  end

  assign wr_addr = pos_mod[wr_pos];
  assign rd_addr = pos_mod[rd_pos];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/i2cseq_step.sv @@
// ----------------------------------------------------------------------------
// i2cseq_step
// Sequencer state, request registers and the per-word transition and
// command logic.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cseq_step #(
  parameter int BUF_DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire i2cseq_pkg::in_item_t item,
  input  wire logic [7:0]           tx_byte,
  output i2cseq_pkg::out_item_t     result,
  output logic      [3:0]           write_pos_next
);

  import i2cseq_pkg::*;

  localparam int        CntMaxInt = (BUF_DEPTH < 31) ? BUF_DEPTH : 31;
  localparam logic [4:0] CNT_MAX  = 5'(CntMaxInt);

  state_t     seq_state, seq_state_next;
  state_t     resume_state, resume_state_next;
  logic [6:0] write_addr, write_addr_next;
  logic [6:0] read_addr, read_addr_next;
  logic [4:0] write_left, write_left_next;
  logic [3:0] write_pos;
  logic [4:0] read_left, read_left_next;
  logic [3:0] read_pos, read_pos_next;
  logic       notify_flag, notify_flag_next;
  logic [4:0] cnt;
  logic [4:0] write_dec;
  logic [4:0] read_dec;

  assign cnt       = (item.byte_count > CNT_MAX) ? CNT_MAX : item.byte_count;
  assign write_dec = (write_left != 5'd0) ? write_left - 5'd1 : 5'd0;
  assign read_dec  = (read_left != 5'd0) ? read_left - 5'd1 : 5'd0;

  always_comb begin
    seq_state_next    = seq_state;
    resume_state_next = resume_state;
    write_addr_next   = write_addr;
    read_addr_next    = read_addr;
    write_left_next   = write_left;
    write_pos_next    = write_pos;
    read_left_next    = read_left;
    read_pos_next     = read_pos;
    notify_flag_next  = notify_flag;
    if (fire) begin
      unique case (item.action) inside
        ACT_WRITE, ACT_READ: begin
          if (seq_state == ST_IDLE && cnt != 5'd0) begin
            if (item.action == ACT_WRITE) begin
              write_addr_next = item.device_address;
              write_left_next = cnt;
            end else begin
              read_addr_next = item.device_address;
              read_left_next = cnt;
            end
            notify_flag_next = item.notify;
          end
        end
        ACT_LOAD: begin
        end
        default: begin
          unique case (seq_state)
            ST_IDLE: begin
              if (write_left != 5'd0) begin
                resume_state_next = ST_TX_START;
                seq_state_next    = ST_WAIT_BUSY;
              end else if (read_left != 5'd0) begin
                resume_state_next = ST_RX_START;
                seq_state_next    = ST_WAIT_BUSY;
              end
            end
            ST_TX_START: begin
              resume_state_next = ST_TX_ADDRESS;
              seq_state_next    = ST_WAIT_START;
            end
            ST_RX_START: begin
              resume_state_next = ST_RX_ADDRESS;
              seq_state_next    = ST_WAIT_START;
            end
            ST_TX_ADDRESS: begin
              write_pos_next    = 4'd0;
              resume_state_next = ST_TX_DATA;
              seq_state_next    = ST_WAIT_TX_ADDRESS;
            end
            ST_RX_ADDRESS: begin
              read_pos_next     = 4'd0;
              resume_state_next = ST_RX_DATA;
              seq_state_next    = ST_WAIT_RX_ADDRESS;
            end
            ST_TX_DATA: begin
              write_left_next = write_dec;
              write_pos_next  = write_pos + 4'd1;
              // A pending read follows a write with a repeated start.
              if (write_dec != 5'd0) begin
                resume_state_next = ST_TX_DATA;
              end else if (read_left != 5'd0) begin
                resume_state_next = ST_RX_START;
              end else begin
                resume_state_next = ST_STOP;
              end
              seq_state_next = ST_WAIT_TX_DATA;
            end
            ST_RX_DATA: begin
              read_left_next    = read_dec;
              read_pos_next     = read_pos + 4'd1;
              resume_state_next = (read_dec != 5'd0) ? ST_RX_DATA : ST_STOP;
              seq_state_next    = ST_WAIT_RX_DATA;
            end
            ST_STOP: begin
              seq_state_next = ST_IDLE;
            end
            ST_WAIT_BUSY: begin
              if (!item.bus_busy) seq_state_next = resume_state;
            end
            ST_WAIT_START: begin
              if (item.start_done) seq_state_next = resume_state;
            end
            ST_WAIT_TX_ADDRESS: begin
              if (item.tx_addr_acked) seq_state_next = resume_state;
            end
            ST_WAIT_RX_ADDRESS: begin
              if (item.rx_addr_acked) seq_state_next = resume_state;
            end
            ST_WAIT_TX_DATA: begin
              if (item.byte_sent) seq_state_next = resume_state;
            end
            ST_WAIT_RX_DATA: begin
              if (item.byte_received) seq_state_next = resume_state;
            end
            default: begin
              seq_state_next = ST_IDLE;
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    result             = '0;
    result.command     = CMD_NONE;
    result.fsm_state   = seq_state_next;
    if (item.action == ACT_TICK) begin
      unique case (seq_state) inside
        ST_IDLE: begin
          if (write_left != 5'd0 || read_left != 5'd0) result.command = CMD_ACK_ON;
        end
        ST_TX_START, ST_RX_START: begin
          result.command = CMD_START;
        end
        ST_TX_ADDRESS: begin
          result.command     = CMD_ADDR_WR;
          result.bus_address = write_addr;
        end
        ST_RX_ADDRESS: begin
          result.command     = CMD_ADDR_RD;
          result.bus_address = read_addr;
        end
        ST_TX_DATA: begin
          result.command   = CMD_SEND;
          result.out_index = write_pos;
          result.out_byte  = tx_byte;
        end
        ST_RX_DATA: begin
          result.command   = CMD_READ;
          result.ack_off   = (read_left <= 5'd1);
          result.out_index = read_pos;
          result.out_byte  = item.data_byte;
        end
        ST_STOP: begin
          result.command  = CMD_STOP;
          result.done_res = notify_flag;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state    <= ST_IDLE;
      resume_state <= ST_IDLE;
      write_addr   <= '0;
      read_addr    <= '0;
      write_left   <= '0;
      write_pos    <= '0;
      read_left    <= '0;
      read_pos     <= '0;
      notify_flag  <= 1'b0;
    end else begin
      seq_state    <= seq_state_next;
      resume_state <= resume_state_next;
      write_addr   <= write_addr_next;
      read_addr    <= read_addr_next;
      write_left   <= write_left_next;
      write_pos    <= write_pos_next;
      read_left    <= read_left_next;
      read_pos     <= read_pos_next;
      notify_flag  <= notify_flag_next;
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_i2c_master_transaction_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// tb_i2c_master_transaction_sequencer_core
// Self-checking bench for the polled I2C master sequencer. A directed table
// walks one write followed by a read with a repeated start. Random traffic
// follows: whole transfers with random counts, interleaved with stray
// requests and loads. Every output word is compared against a pinned table
// value or a behavioral copy of the sequencer, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_i2c_master_transaction_sequencer_core;
  import i2cseq_pkg::*;

  localparam int BUF_DEPTH    = 16;
  localparam int RANDOM_WORDS = 1250;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_SHOWN    = 10;
  localparam logic [4:0] COUNT_CAP = 5'd16;

  // Event flag masks of a poll tick.
  localparam logic [5:0] F_BUSY  = 6'b000001;
  localparam logic [5:0] F_START = 6'b000010;
  localparam logic [5:0] F_TXA   = 6'b000100;
  localparam logic [5:0] F_RXA   = 6'b001000;
  localparam logic [5:0] F_SENT  = 6'b010000;
  localparam logic [5:0] F_RCVD  = 6'b100000;
  localparam logic [5:0] F_NONE  = 6'b000000;

  typedef struct {
    in_item_t  stim;
    bit        pinned;
    out_item_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;

  i2c_master_transaction_sequencer_core #(
    .BUF_DEPTH(BUF_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sequencer state as the bench expects it.
  state_t      seq_st;
  state_t      resume_st;
  logic [6:0]  wr_addr, rd_addr;
  logic [4:0]  wr_left, rd_left;
  logic [3:0]  wr_pos, rd_pos;
  logic        notify_q;
  logic [7:0]  tx_bytes [BUF_DEPTH];
  bit          tx_loaded [BUF_DEPTH];

  out_item_t   cmd_due [$];
  in_item_t    planned_words [$];
  row_t        plan_rows [$];

  int cycles;
  int fed_words;
  int useful_words;
  int burst_left;
  int cmd_mismatches;
  int stray_cmds;
  int n_checked, n_stops, n_sends, n_reads;
  bit hold_done;

  function automatic in_item_t tick_word(input logic [7:0] d, input logic [5:0] f);
    in_item_t w;
    w = '0;
    w.action        = ACT_TICK;
    w.data_byte     = d;
    w.bus_busy      = f[0];
    w.start_done    = f[1];
    w.tx_addr_acked = f[2];
    w.rx_addr_acked = f[3];
    w.byte_sent     = f[4];
    w.byte_received = f[5];
    return w;
  endfunction

  function automatic in_item_t req_word(input action_t a, input logic [6:0] addr,
                                        input logic [4:0] cnt, input logic ntf);
    in_item_t w;
    w = '0;
    w.action         = a;
    w.device_address = addr;
    w.byte_count     = cnt;
    w.notify         = ntf;
    return w;
  endfunction

  function automatic in_item_t load_word(input logic [3:0] idx, input logic [7:0] d);
    in_item_t w;
    w = '0;
    w.action     = ACT_LOAD;
    w.byte_index = idx;
    w.data_byte  = d;
    return w;
  endfunction

  function automatic out_item_t cmd_word(input cmd_t c, input logic ack, input logic [6:0] addr,
                                         input logic [7:0] b, input logic [3:0] idx,
                                         input logic dn, input state_t st);
    out_item_t r;
    r.command     = c;
    r.ack_off     = ack;
    r.bus_address = addr;
    r.out_byte    = b;
    r.out_index   = idx;
    r.done_res    = dn;
    r.fsm_state   = st;
    return r;
  endfunction

  // One step of the sequencer: updates the expected state and returns the
  // command word the block should emit for this input word.
  function automatic out_item_t sequencer_step(input in_item_t w);
    out_item_t  r;
    logic [4:0] cnt;
    r = '0;
    r.command = CMD_NONE;
    case (w.action) inside
      ACT_WRITE, ACT_READ: begin
        cnt = (w.byte_count > COUNT_CAP) ? COUNT_CAP : w.byte_count;
        if (seq_st == ST_IDLE && cnt != 0) begin
          if (w.action == ACT_WRITE) begin
            wr_addr = w.device_address;
            wr_left = cnt;
          end else begin
            rd_addr = w.device_address;
            rd_left = cnt;
          end
          notify_q = w.notify;
        end
      end
      ACT_LOAD: begin
        tx_bytes[w.byte_index]  = w.data_byte;
        tx_loaded[w.byte_index] = 1'b1;
      end
      default: begin
        case (seq_st) inside
          ST_IDLE: begin
            if (wr_left != 0 || rd_left != 0) begin
              r.command = CMD_ACK_ON;
              resume_st = (wr_left != 0) ? ST_TX_START : ST_RX_START;
              seq_st    = ST_WAIT_BUSY;
            end
          end
          ST_TX_START, ST_RX_START: begin
            r.command = CMD_START;
            resume_st = (seq_st == ST_TX_START) ? ST_TX_ADDRESS : ST_RX_ADDRESS;
            seq_st    = ST_WAIT_START;
          end
          ST_TX_ADDRESS: begin
            r.command     = CMD_ADDR_WR;
            r.bus_address = wr_addr;
            wr_pos        = '0;
            resume_st     = ST_TX_DATA;
            seq_st        = ST_WAIT_TX_ADDRESS;
          end
          ST_RX_ADDRESS: begin
            r.command     = CMD_ADDR_RD;
            r.bus_address = rd_addr;
            rd_pos        = '0;
            resume_st     = ST_RX_DATA;
            seq_st        = ST_WAIT_RX_ADDRESS;
          end
          ST_TX_DATA: begin
            r.command   = CMD_SEND;
            r.out_index = wr_pos;
            r.out_byte  = tx_bytes[wr_pos];
            if (wr_left != 0) wr_left--;
            wr_pos++;
            // A read queued behind the write goes out after a repeated start.
            if (wr_left != 0) resume_st = ST_TX_DATA;
            else if (rd_left != 0) resume_st = ST_RX_START;
            else resume_st = ST_STOP;
            seq_st = ST_WAIT_TX_DATA;
          end
          ST_RX_DATA: begin
            r.command   = CMD_READ;
            r.ack_off   = (rd_left <= 1);
            r.out_index = rd_pos;
            r.out_byte  = w.data_byte;
            if (rd_left != 0) rd_left--;
            rd_pos++;
            resume_st = (rd_left != 0) ? ST_RX_DATA : ST_STOP;
            seq_st    = ST_WAIT_RX_DATA;
          end
          ST_STOP: begin
            r.command  = CMD_STOP;
            r.done_res = notify_q;
            seq_st     = ST_IDLE;
          end
          ST_WAIT_BUSY:       if (!w.bus_busy) seq_st = resume_st;
          ST_WAIT_START:      if (w.start_done) seq_st = resume_st;
          ST_WAIT_TX_ADDRESS: if (w.tx_addr_acked) seq_st = resume_st;
          ST_WAIT_RX_ADDRESS: if (w.rx_addr_acked) seq_st = resume_st;
          ST_WAIT_TX_DATA:    if (w.byte_sent) seq_st = resume_st;
          ST_WAIT_RX_DATA:    if (w.byte_received) seq_st = resume_st;
          default:            seq_st = ST_IDLE;
        endcase
      end
    endcase
    r.fsm_state = seq_st;
    return r;
  endfunction

  function automatic logic [4:0] pick_count();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 80) return 5'($urandom_range(4, 1));
    if (p < 93) return 5'($urandom_range(16, 5));
    return 5'($urandom_range(31, 17));
  endfunction

  // Queues one well-formed transfer: any missing transmit bytes are loaded
  // before the write request so that no unloaded entry is ever sent.
  function automatic void plan_transfer();
    int unsigned kind;
    logic [4:0]  wcnt, rcnt;
    kind = $urandom_range(2);
    wcnt = pick_count();
    rcnt = pick_count();
    if (kind != 1) begin
      for (int i = 0; i < BUF_DEPTH && i < wcnt; i++)
        if (!tx_loaded[i]) planned_words.push_back(load_word(4'(i), 8'($urandom)));
      planned_words.push_back(req_word(ACT_WRITE, 7'($urandom), wcnt, 1'($urandom)));
    end
    if (kind != 0)
      planned_words.push_back(req_word(ACT_READ, 7'($urandom), rcnt, 1'($urandom)));
  endfunction

  function automatic in_item_t next_word();
    in_item_t    w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (planned_words.size() != 0) return planned_words.pop_front();
    if (seq_st == ST_IDLE && wr_left == 0 && rd_left == 0 && pick >= 10) begin
      plan_transfer();
      return planned_words.pop_front();
    end
    if (pick < 10) begin
      // Noise. While idle a request carries a zero count and is dropped.
      case ($urandom_range(2))
        0: w = load_word(4'($urandom), 8'($urandom));
        1: w = req_word(ACT_WRITE, 7'($urandom),
                        (seq_st == ST_IDLE) ? 5'd0 : 5'($urandom), 1'($urandom));
        default: w = req_word(ACT_READ, 7'($urandom),
                              (seq_st == ST_IDLE) ? 5'd0 : 5'($urandom), 1'($urandom));
      endcase
    end else begin
      w = tick_word(8'($urandom), 6'($urandom));
    end
    return w;
  endfunction

  task automatic add_row(input in_item_t w);
    row_t r;
    r.stim   = w;
    r.pinned = 1'b0;
    r.want   = '0;
    plan_rows.push_back(r);
  endtask

  task automatic add_pinned(input in_item_t w, input out_item_t want);
    row_t r;
    r.stim   = w;
    r.pinned = 1'b1;
    r.want   = want;
    plan_rows.push_back(r);
  endtask

  task automatic push_word(input in_item_t w, input bit pinned, input out_item_t want);
    out_item_t model_cmd;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, w.byte_received, w.byte_sent, w.rx_addr_acked, w.tx_addr_acked,
                 w.start_done, w.bus_busy, w.data_byte, w.byte_index, w.notify,
                 w.byte_count, w.device_address};
    s_tuser  <= w.action;
    do @(posedge clk); while (s_tready !== 1'b1);
    model_cmd = sequencer_step(w);
    cmd_due.push_back(pinned ? want : model_cmd);
    fed_words++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(200, 60) : $urandom_range(16, 1);
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d command words outstanding", cycles,
               cmd_due.size());
      $display("FAIL i2c_master_transaction_sequencer_core");
      $finish;
    end
  end

  // Receiver: switches between stall patterns, and holds off once for a
  // long stretch so that the block backs up into its input.
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned phase;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && fed_words >= HOLD_AT) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(3);
          mode_left = $urandom_range(256, 64);
        end
        mode_left--;
        phase++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(99) < 70);
          2: m_tready <= (phase % 3 == 0);
          default: m_tready <= ($urandom_range(99) < 25);
        endcase
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t got;
    out_item_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got.command     = cmd_t'(m_tuser);
      got.ack_off     = m_tdata[0];
      got.bus_address = m_tdata[7:1];
      got.out_byte    = m_tdata[15:8];
      got.out_index   = m_tdata[19:16];
      got.done_res    = m_tdata[20];
      got.fsm_state   = m_tdata[24:21];
      if (cmd_due.size() == 0) begin
        stray_cmds++;
        if (cmd_mismatches + stray_cmds <= MAX_SHOWN)
          $display("Unexpected command word %h/%h at cycle %0d", m_tuser, m_tdata, cycles);
      end else begin
        want = cmd_due.pop_front();
        n_checked++;
        if (got.command == CMD_STOP) n_stops++;
        if (got.command == CMD_SEND) n_sends++;
        if (got.command == CMD_READ) n_reads++;
        if (got.command !== want.command || got.ack_off !== want.ack_off ||
            got.bus_address !== want.bus_address || got.out_byte !== want.out_byte ||
            got.out_index !== want.out_index || got.done_res !== want.done_res ||
            got.fsm_state !== want.fsm_state) begin
          cmd_mismatches++;
          if (cmd_mismatches + stray_cmds <= MAX_SHOWN)
            $display({"Mismatch at cycle %0d: expected cmd %0d ack_off %0d addr %h byte %h ",
                      "idx %0d done %0d state %0d, got cmd %0d ack_off %0d addr %h byte %h ",
                      "idx %0d done %0d state %0d"}, cycles,
                     want.command, want.ack_off, want.bus_address, want.out_byte,
                     want.out_index, want.done_res, want.fsm_state,
                     got.command, got.ack_off, got.bus_address, got.out_byte,
                     got.out_index, got.done_res, got.fsm_state);
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t w;
    bit       dropped;
    seq_st    = ST_IDLE;
    resume_st = ST_IDLE;
    wr_addr   = '0;
    rd_addr   = '0;
    wr_left   = '0;
    rd_left   = '0;
    wr_pos    = '0;
    rd_pos    = '0;
    notify_q  = 1'b0;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      tx_bytes[i]  = '0;
      tx_loaded[i] = 1'b0;
    end
    burst_left = $urandom_range(16, 1);

    // One write of a single byte, then a single-byte read behind a repeated
    // start; stray requests and loads are mixed in along the way.
    add_pinned(tick_word(8'h00, F_NONE),
               cmd_word(CMD_NONE, 1'b0, 7'd0, 8'h00, 4'd0, 1'b0, ST_IDLE));
    add_row(load_word(4'd0, 8'hFF));
    add_row(load_word(4'd15, 8'h00));
    add_pinned(req_word(ACT_WRITE, 7'h55, 5'd0, 1'b1),
               cmd_word(CMD_NONE, 1'b0, 7'd0, 8'h00, 4'd0, 1'b0, ST_IDLE));
    add_row(req_word(ACT_WRITE, 7'h7F, 5'd1, 1'b1));
    add_row(req_word(ACT_READ, 7'h00, 5'd1, 1'b1));
    add_row(tick_word(8'h00, F_BUSY));
    add_pinned(req_word(ACT_WRITE, 7'h03, 5'd5, 1'b0),
               cmd_word(CMD_NONE, 1'b0, 7'd0, 8'h00, 4'd0, 1'b0, ST_WAIT_BUSY));
    add_row(tick_word(8'h00, F_BUSY));
    add_row(tick_word(8'hFF, ~F_BUSY));
    add_row(tick_word(8'h00, F_NONE));
    add_row(tick_word(8'h00, F_START));
    add_pinned(tick_word(8'h00, F_NONE),
               cmd_word(CMD_ADDR_WR, 1'b0, 7'h7F, 8'h00, 4'd0, 1'b0, ST_WAIT_TX_ADDRESS));
    add_row(tick_word(8'h00, F_TXA));
    add_row(load_word(4'd1, 8'h3C));
    add_pinned(tick_word(8'h00, F_NONE),
               cmd_word(CMD_SEND, 1'b0, 7'd0, 8'hFF, 4'd0, 1'b0, ST_WAIT_TX_DATA));
    add_row(tick_word(8'h00, F_SENT));
    add_row(tick_word(8'h00, F_NONE));
    add_row(tick_word(8'h00, F_START));
    add_pinned(tick_word(8'h00, F_NONE),
               cmd_word(CMD_ADDR_RD, 1'b0, 7'h00, 8'h00, 4'd0, 1'b0, ST_WAIT_RX_ADDRESS));
    add_row(tick_word(8'h00, F_RXA));
    add_pinned(tick_word(8'hFF, F_NONE),
               cmd_word(CMD_READ, 1'b1, 7'd0, 8'hFF, 4'd0, 1'b0, ST_WAIT_RX_DATA));
    add_row(tick_word(8'h00, F_RCVD));
    add_pinned(tick_word(8'h00, F_NONE),
               cmd_word(CMD_STOP, 1'b0, 7'd0, 8'h00, 4'd0, 1'b1, ST_IDLE));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan_rows[i]) push_word(plan_rows[i].stim, plan_rows[i].pinned, plan_rows[i].want);

    while (useful_words < RANDOM_WORDS) begin
      w = next_word();
      dropped = (w.action == ACT_WRITE || w.action == ACT_READ) &&
                (seq_st != ST_IDLE || w.byte_count == 0);
      if (!dropped) useful_words++;
      push_word(w, 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (cmd_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d command words from %0d input words over %0d cycles.",
             n_checked, fed_words, cycles);
    $display("Transfers stopped: %0d, bytes sent: %0d, bytes read: %0d, long output hold: %0d.",
             n_stops, n_sends, n_reads, hold_done);
    if (cmd_mismatches == 0 && stray_cmds == 0 && cmd_due.size() == 0) begin
      $display("PASS i2c_master_transaction_sequencer_core");
    end else begin
      $display("%0d mismatches, %0d unexpected words, %0d words never seen",
               cmd_mismatches, stray_cmds, cmd_due.size());
      $display("FAIL i2c_master_transaction_sequencer_core");
    end
    $finish;
  end

endmodule
